// File: sv/gwc_pkg.sv
`timescale 1ns / 1ps
package gwc_pkg;

   localparam int MAX_POINTS = 64;
   localparam int ADDR_W = $clog2(MAX_POINTS);
   localparam int COUNT_W = ADDR_W + 1;

   localparam logic [COUNT_W-1:0] REMOVED = COUNT_W'(MAX_POINTS);

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_UNSORTED = 2'd1;
   localparam logic [1:0] ST_OVERFLOW = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE,
      S_WI, S_WI2, S_WR, S_WC,
      S_BLD,
      S_SU_RD, S_SU_W, S_SU_CMP,
      S_SD_RD1, S_SD_W1, S_SD_SEL, S_SD_W2, S_SD_CMP,
      S_SW_RD, S_SW_LT, S_SW1, S_SW2,
      S_M_TOP, S_M_T2, S_M_T3,
      S_M_RK, S_M_RK2, S_M_RK3,
      S_M_W, S_M_W2, S_M_W3,
      S_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RET_BUILD,
      RET_REMOVE,
      RET_WALK
   } ret_type;

   typedef enum logic [1:0] {
      SWK_UP,
      SWK_DOWN,
      SWK_REMOVE
   } swap_kind_type;

   typedef struct packed {
      logic [ADDR_W-1:0]  start;
      logic [COUNT_W-1:0] length;
      logic [1:0]         status;
      logic               last;
   } rsp_type;

endpackage

// File: sv/greedy_window_cluster_finder.sv
`timescale 1ns / 1ps
// Channel  Direction  Ports                                      Handshake
// req      in         req_position, req_last_point               req_valid / req_ready
// rsp      out        rsp_cluster_start, rsp_cluster_length,     rsp_valid / rsp_ready
//                     rsp_status, rsp_last_result
// csr      in         csr_wdata                                  csr_we, no wait
//
// Points load at one word per cycle into single-write, dual-read memories.
// After the last point the sequencer works out each point's weight by stepping
// its window's end, then builds a max-heap of the weights, sifting entries up
// and down one heap level at a time; a swap writes two heap slots, and the swap
// that starts a removal first reads both slots.
// The block does not take words during the search; results leave through an
// output register. Reset is synchronous and clears the counts and flags.
module greedy_window_cluster_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [31:0] req_position,
   input  logic        req_last_point,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [5:0]  rsp_cluster_start,
   output logic [6:0]  rsp_cluster_length,
   output logic [1:0]  rsp_status,
   output logic        rsp_last_result
);
   import gwc_pkg::*;

   logic    push;
   logic    out_free;
   rsp_type rsp_next;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   assign out_free = !rsp_valid_ff || rsp_ready;

   gwc_engine u_engine (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata),
      .in_take(req_valid && req_ready),
      .in_position(req_position),
      .in_last(req_last_point),
      .in_ready(req_ready),
      .out_free(out_free),
      .out_push(push),
      .out_rsp(rsp_next)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in = rsp_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_in = rsp_next;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_cluster_start = rsp_ff.start;
   assign rsp_cluster_length = rsp_ff.length;
   assign rsp_status = rsp_ff.status;
   assign rsp_last_result = rsp_ff.last;

   a_push_free: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result pushed over a pending word");

   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_cluster_length == '0) && rsp_last_result)
      else $error("error word has a cluster or is not last");

   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == ST_OK)) |-> (rsp_cluster_length != '0))
      else $error("cluster of zero length");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      push |-> !req_ready)
      else $error("input taken while a result is produced");

endmodule

// File: sv/gwc_ram.sv
`timescale 1ns / 1ps
module gwc_ram #(
   parameter int WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      we,
   input  logic [gwc_pkg::ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]          wdata,
   input  logic [gwc_pkg::ADDR_W-1:0] raddr_a,
   input  logic [gwc_pkg::ADDR_W-1:0] raddr_b,
   output logic [WIDTH-1:0]          rdata_a,
   output logic [WIDTH-1:0]          rdata_b
);
   import gwc_pkg::*;

   logic [WIDTH-1:0] mem_ff [MAX_POINTS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_a <= mem_ff[raddr_a];
      rdata_b <= mem_ff[raddr_b];
   end

endmodule

// File: sv/gwc_engine.sv
`timescale 1ns / 1ps
module gwc_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [31:0]           csr_wdata,
   input  logic                  in_take,
   input  logic signed [31:0]    in_position,
   input  logic                  in_last,
   output logic                  in_ready,
   input  logic                  out_free,
   output logic                  out_push,
   output gwc_pkg::rsp_type      out_rsp
);
   import gwc_pkg::*;

   state_type          state_ff, state_in;
   ret_type            ret_ff, ret_in;
   swap_kind_type      swk_ff, swk_in;
   logic [31:0]        width_ff, width_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [COUNT_W-1:0] hsz_ff, hsz_in;
   logic               ovf_ff, ovf_in;
   logic               uns_ff, uns_in;
   logic signed [31:0] prev_ff, prev_in;
   logic [COUNT_W-1:0] i_ff, i_in;
   logic [COUNT_W-1:0] r_ff, r_in;
   logic signed [33:0] lim_ff, lim_in;
   logic [COUNT_W-1:0] nx_ff, nx_in;
   logic [COUNT_W-1:0] base_ff, base_in;
   logic [COUNT_W-1:0] oth_ff, oth_in;
   logic [ADDR_W-1:0]  pa_ff, pa_in;
   logic [ADDR_W-1:0]  pb_ff, pb_in;
   logic [COUNT_W-1:0] vc_ff, vc_in;
   logic               vcv_ff, vcv_in;
   logic [ADDR_W-1:0]  start_ff, start_in;
   logic [COUNT_W-1:0] len_ff, len_in;
   logic [COUNT_W-1:0] end_ff, end_in;
   logic [COUNT_W-1:0] k_ff, k_in;
   logic [1:0]         stat_ff, stat_in;

   logic               pts_we, wt_we, hs_we, sop_we;
   logic [ADDR_W-1:0]  pts_wa, wt_wa, hs_wa, sop_wa;
   logic [ADDR_W-1:0]  pts_ra, pts_rb, wt_ra, wt_rb, hs_ra, hs_rb, sop_ra, sop_rb;
   logic [31:0]        pts_wd, pts_qa, pts_qb;
   logic [COUNT_W-1:0] wt_wd, wt_qa, wt_qb, sop_wd, sop_qa, sop_qb;
   logic [ADDR_W-1:0]  hs_wd, hs_qa, hs_qb;

   logic [COUNT_W:0]   c1, c2;
   logic               v1v, v2v, pick2;
   logic [COUNT_W-1:0] parent, rem, l_raw, l_clamp, idx7;
   logic               vv;

   gwc_ram #(.WIDTH(32)) u_pts (
      .clock(clock), .we(pts_we), .waddr(pts_wa), .wdata(pts_wd),
      .raddr_a(pts_ra), .raddr_b(pts_rb), .rdata_a(pts_qa), .rdata_b(pts_qb));
   gwc_ram #(.WIDTH(COUNT_W)) u_wt (
      .clock(clock), .we(wt_we), .waddr(wt_wa), .wdata(wt_wd),
      .raddr_a(wt_ra), .raddr_b(wt_rb), .rdata_a(wt_qa), .rdata_b(wt_qb));
   gwc_ram #(.WIDTH(ADDR_W)) u_hs (
      .clock(clock), .we(hs_we), .waddr(hs_wa), .wdata(hs_wd),
      .raddr_a(hs_ra), .raddr_b(hs_rb), .rdata_a(hs_qa), .rdata_b(hs_qb));
   gwc_ram #(.WIDTH(COUNT_W)) u_sop (
      .clock(clock), .we(sop_we), .waddr(sop_wa), .wdata(sop_wd),
      .raddr_a(sop_ra), .raddr_b(sop_rb), .rdata_a(sop_qa), .rdata_b(sop_qb));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         width_ff <= '0;
         cnt_ff <= '0;
         hsz_ff <= '0;
         ovf_ff <= 1'b0;
         uns_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         width_ff <= width_in;
         cnt_ff <= cnt_in;
         hsz_ff <= hsz_in;
         ovf_ff <= ovf_in;
         uns_ff <= uns_in;
      end
      ret_ff <= ret_in;
      swk_ff <= swk_in;
      prev_ff <= prev_in;
      i_ff <= i_in;
      r_ff <= r_in;
      lim_ff <= lim_in;
      nx_ff <= nx_in;
      base_ff <= base_in;
      oth_ff <= oth_in;
      pa_ff <= pa_in;
      pb_ff <= pb_in;
      vc_ff <= vc_in;
      vcv_ff <= vcv_in;
      start_ff <= start_in;
      len_ff <= len_in;
      end_ff <= end_in;
      k_ff <= k_in;
      stat_ff <= stat_in;
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      swk_in = swk_ff;
      width_in = csr_we ? csr_wdata : width_ff;
      cnt_in = cnt_ff;
      hsz_in = hsz_ff;
      ovf_in = ovf_ff;
      uns_in = uns_ff;
      prev_in = prev_ff;
      i_in = i_ff;
      r_in = r_ff;
      lim_in = lim_ff;
      nx_in = nx_ff;
      base_in = base_ff;
      oth_in = oth_ff;
      pa_in = pa_ff;
      pb_in = pb_ff;
      vc_in = vc_ff;
      vcv_in = vcv_ff;
      start_in = start_ff;
      len_in = len_ff;
      end_in = end_ff;
      k_in = k_ff;
      stat_in = stat_ff;

      pts_we = 1'b0; pts_wa = '0; pts_wd = '0; pts_ra = '0; pts_rb = '0;
      wt_we = 1'b0;  wt_wa = '0;  wt_wd = '0;  wt_ra = '0;  wt_rb = '0;
      hs_we = 1'b0;  hs_wa = '0;  hs_wd = '0;  hs_ra = '0;  hs_rb = '0;
      sop_we = 1'b0; sop_wa = '0; sop_wd = '0; sop_ra = '0; sop_rb = '0;

      in_ready = 1'b0;
      out_push = 1'b0;
      out_rsp.start = start_ff;
      out_rsp.length = len_ff;
      out_rsp.status = stat_ff;
      out_rsp.last = (stat_ff != ST_OK) || (hsz_ff == '0);

      c1 = {nx_ff, 1'b1};
      c2 = {nx_ff, 1'b0} + (COUNT_W+1)'(2);
      v1v = c1 < {1'b0, hsz_ff};
      v2v = c2 < {1'b0, hsz_ff};
      pick2 = v2v && (!v1v || (wt_qa < wt_qb));
      parent = (nx_ff - COUNT_W'(1)) >> 1;
      rem = cnt_ff - {1'b0, start_ff};
      l_raw = (wt_qa == '0) ? COUNT_W'(1) : wt_qa;
      l_clamp = (l_raw > rem) ? rem : l_raw;
      idx7 = {1'b0, start_ff} - k_ff;
      vv = nx_ff < hsz_ff;

      unique case (state_ff)
         S_IDLE: begin
            in_ready = 1'b1;
            if (in_take) begin
               if (cnt_ff < COUNT_W'(MAX_POINTS)) begin
                  pts_we = 1'b1;
                  pts_wa = cnt_ff[ADDR_W-1:0];
                  pts_wd = in_position;
                  cnt_in = cnt_ff + COUNT_W'(1);
                  prev_in = in_position;
                  if ((cnt_ff != '0) && (in_position < prev_ff)) begin
                     uns_in = 1'b1;
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (in_last) begin
                  start_in = '0;
                  len_in = '0;
                  i_in = '0;
                  r_in = '0;
                  if (ovf_in) begin
                     stat_in = ST_OVERFLOW;
                     state_in = S_EMIT;
                  end else if (uns_in) begin
                     stat_in = ST_UNSORTED;
                     state_in = S_EMIT;
                  end else begin
                     stat_in = ST_OK;
                     state_in = S_WI;
                  end
               end
            end
         end
         S_WI: begin
            pts_ra = i_ff[ADDR_W-1:0];
            state_in = S_WI2;
         end
         S_WI2: begin
            lim_in = {{2{pts_qa[31]}}, pts_qa} + {2'b00, width_ff};
            state_in = S_WR;
         end
         S_WR, S_WC: begin
            pts_rb = r_ff[ADDR_W-1:0];
            if ((state_ff == S_WR) && (r_ff < cnt_ff)) begin
               state_in = S_WC;
            end else if ((state_ff == S_WC) &&
                         ($signed({{2{pts_qb[31]}}, pts_qb}) <= lim_ff)) begin
               r_in = r_ff + COUNT_W'(1);
               state_in = S_WR;
            end else begin
               wt_we = 1'b1;
               wt_wa = i_ff[ADDR_W-1:0];
               wt_wd = r_ff - i_ff;
               if (i_ff + COUNT_W'(1) == cnt_ff) begin
                  i_in = '0;
                  state_in = S_BLD;
               end else begin
                  i_in = i_ff + COUNT_W'(1);
                  state_in = S_WI;
               end
            end
         end
         S_BLD: begin
            sop_we = 1'b1;
            sop_wa = i_ff[ADDR_W-1:0];
            sop_wd = i_ff;
            hs_we = 1'b1;
            hs_wa = i_ff[ADDR_W-1:0];
            hs_wd = i_ff[ADDR_W-1:0];
            hsz_in = i_ff + COUNT_W'(1);
            nx_in = i_ff;
            base_in = i_ff;
            ret_in = RET_BUILD;
            state_in = S_SU_RD;
         end
         S_SU_RD: begin
            hs_ra = nx_ff[ADDR_W-1:0];
            hs_rb = parent[ADDR_W-1:0];
            oth_in = parent;
            state_in = (nx_ff == '0) ? S_SD_RD1 : S_SU_W;
            if (nx_ff == '0) begin
               nx_in = base_ff;
            end
         end
         S_SU_W: begin
            pa_in = hs_qa;
            pb_in = hs_qb;
            wt_ra = hs_qa;
            wt_rb = hs_qb;
            state_in = S_SU_CMP;
         end
         S_SU_CMP: begin
            if (vv && (wt_qa > wt_qb)) begin
               swk_in = SWK_UP;
               state_in = S_SW1;
            end else begin
               nx_in = base_ff;
               state_in = S_SD_RD1;
            end
         end
         S_SD_RD1: begin
            hs_ra = c1[ADDR_W-1:0];
            hs_rb = c2[ADDR_W-1:0];
            state_in = S_SD_W1;
         end
         S_SD_W1: begin
            pa_in = hs_qa;
            pb_in = hs_qb;
            wt_ra = hs_qa;
            wt_rb = hs_qb;
            state_in = S_SD_SEL;
         end
         S_SD_SEL: begin
            oth_in = pick2 ? c2[COUNT_W-1:0] : c1[COUNT_W-1:0];
            pb_in = pick2 ? pb_ff : pa_ff;
            vc_in = pick2 ? wt_qb : wt_qa;
            vcv_in = v1v || v2v;
            hs_ra = nx_ff[ADDR_W-1:0];
            state_in = S_SD_W2;
         end
         S_SD_W2: begin
            pa_in = hs_qa;
            wt_ra = hs_qa;
            state_in = S_SD_CMP;
         end
         S_SD_CMP: begin
            if (vcv_ff && (!vv || (wt_qa < vc_ff))) begin
               swk_in = SWK_DOWN;
               state_in = S_SW1;
            end else begin
               unique case (ret_ff)
                  RET_BUILD: begin
                     if (i_ff + COUNT_W'(1) == cnt_ff) begin
                        state_in = S_M_TOP;
                     end else begin
                        i_in = i_ff + COUNT_W'(1);
                        state_in = S_BLD;
                     end
                  end
                  RET_REMOVE: state_in = S_M_RK3;
                  RET_WALK: state_in = S_M_W3;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SW_RD: begin
            hs_ra = nx_ff[ADDR_W-1:0];
            hs_rb = oth_ff[ADDR_W-1:0];
            state_in = S_SW_LT;
         end
         S_SW_LT: begin
            pa_in = hs_qa;
            pb_in = hs_qb;
            state_in = S_SW1;
         end
         S_SW1: begin
            hs_we = 1'b1;
            hs_wa = nx_ff[ADDR_W-1:0];
            hs_wd = pb_ff;
            sop_we = 1'b1;
            sop_wa = pa_ff;
            sop_wd = oth_ff;
            state_in = S_SW2;
         end
         S_SW2: begin
            hs_we = 1'b1;
            hs_wa = oth_ff[ADDR_W-1:0];
            hs_wd = pa_ff;
            sop_we = 1'b1;
            sop_wa = pb_ff;
            sop_wd = nx_ff;
            unique case (swk_ff)
               SWK_UP: begin
                  nx_in = oth_ff;
                  state_in = S_SU_RD;
               end
               SWK_DOWN: begin
                  nx_in = oth_ff;
                  state_in = S_SD_RD1;
               end
               default: begin
                  nx_in = base_ff;
                  state_in = S_SU_RD;
               end
            endcase
         end
         S_M_TOP: begin
            hs_ra = '0;
            state_in = S_M_T2;
         end
         S_M_T2: begin
            start_in = hs_qa;
            wt_ra = hs_qa;
            pts_ra = hs_qa;
            state_in = S_M_T3;
         end
         S_M_T3: begin
            len_in = l_clamp;
            end_in = {1'b0, start_ff} + l_clamp;
            lim_in = {{2{pts_qa[31]}}, pts_qa} - {2'b00, width_ff};
            k_in = {1'b0, start_ff};
            state_in = S_M_RK;
         end
         S_M_RK: begin
            sop_ra = k_ff[ADDR_W-1:0];
            if (k_ff == end_ff) begin
               k_in = COUNT_W'(1);
               state_in = S_M_W;
            end else begin
               state_in = S_M_RK2;
            end
         end
         S_M_RK2: begin
            if (sop_qa >= REMOVED) begin
               k_in = k_ff + COUNT_W'(1);
               state_in = S_M_RK;
            end else if (sop_qa < hsz_ff) begin
               hsz_in = hsz_ff - COUNT_W'(1);
               nx_in = sop_qa;
               base_in = sop_qa;
               oth_in = hsz_ff - COUNT_W'(1);
               ret_in = RET_REMOVE;
               swk_in = SWK_REMOVE;
               state_in = S_SW_RD;
            end else begin
               state_in = S_M_RK3;
            end
         end
         S_M_RK3: begin
            sop_we = 1'b1;
            sop_wa = k_ff[ADDR_W-1:0];
            sop_wd = REMOVED;
            k_in = k_ff + COUNT_W'(1);
            state_in = S_M_RK;
         end
         S_M_W: begin
            pts_ra = idx7[ADDR_W-1:0];
            sop_rb = idx7[ADDR_W-1:0];
            state_in = (k_ff > {1'b0, start_ff}) ? S_EMIT : S_M_W2;
         end
         S_M_W2: begin
            if (($signed({{2{pts_qa[31]}}, pts_qa}) < lim_ff) || (sop_qb >= REMOVED)) begin
               state_in = S_EMIT;
            end else if (sop_qb < hsz_ff) begin
               wt_we = 1'b1;
               wt_wa = idx7[ADDR_W-1:0];
               wt_wd = k_ff;
               nx_in = sop_qb;
               base_in = sop_qb;
               ret_in = RET_WALK;
               state_in = S_SU_RD;
            end else begin
               state_in = S_M_W3;
            end
         end
         S_M_W3: begin
            k_in = k_ff + COUNT_W'(1);
            state_in = S_M_W;
         end
         S_EMIT: begin
            if (out_free) begin
               out_push = 1'b1;
               if (out_rsp.last) begin
                  cnt_in = '0;
                  hsz_in = '0;
                  ovf_in = 1'b0;
                  uns_in = 1'b0;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_M_TOP;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

// File: sim/greedy_window_cluster_finder_tb.sv
`timescale 1ns / 1ps
module greedy_window_cluster_finder_tb;
   import gwc_pkg::*;

   localparam int IDLE_LIMIT = 40000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic [5:0] start;
      logic [6:0] length;
      logic [1:0] status;
      logic       last;
   } cluster_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_we = 1'b0;
   logic [31:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic signed [31:0] req_position = '0;
   logic        req_last_point = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [5:0]  rsp_cluster_start;
   logic [6:0]  rsp_cluster_length;
   logic [1:0]  rsp_status;
   logic        rsp_last_result;

   greedy_window_cluster_finder DUT (
      .clock(clock), .reset(reset), .csr_we(csr_we), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready), .req_position(req_position),
      .req_last_point(req_last_point), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_cluster_start(rsp_cluster_start), .rsp_cluster_length(rsp_cluster_length),
      .rsp_status(rsp_status), .rsp_last_result(rsp_last_result)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Shadow copy of the block's state.
   int          pts [MAX_POINTS];
   int          wt [MAX_POINTS];
   int          hs [MAX_POINTS];
   int          sp [MAX_POINTS];
   int          hsize = 0;
   int          pcount = 0;
   int          eflags = 0;
   logic [31:0] width_q = '0;

   cluster_word_type pending_clusters[$];
   int errors = 0;
   int words_sent = 0;
   int clusters_seen = 0;
   int sets_sent = 0;
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;

   function automatic int clip(int i);
      return (i >= 0 && i < MAX_POINTS) ? i : 0;
   endfunction

   function automatic int slot_weight(int n);
      if (n < hsize && n < MAX_POINTS) return wt[clip(hs[n])];
      return -1;
   endfunction

   function automatic void swap_slots(int a, int b);
      int pa, pb;
      a = clip(a);
      b = clip(b);
      pa = hs[a];
      pb = hs[b];
      sp[clip(pa)] = b;
      sp[clip(pb)] = a;
      hs[a] = pb;
      hs[b] = pa;
   endfunction

   function automatic void heap_up(int n);
      int p;
      while (n > 0) begin
         p = (n - 1) >> 1;
         if (slot_weight(n) > slot_weight(p)) begin
            swap_slots(n, p);
            n = p;
         end else break;
      end
   endfunction

   function automatic void heap_down(int n);
      int c1, c2, v, v1, v2, c;
      while (n < MAX_POINTS) begin
         c1 = 2 * n + 1;
         c2 = 2 * n + 2;
         v = slot_weight(n);
         v1 = slot_weight(c1);
         v2 = slot_weight(c2);
         if (v < v1 || v < v2) begin
            c = (v1 < v2) ? c2 : c1;
            swap_slots(n, c);
            n = c;
         end else break;
      end
   endfunction

   function automatic void heap_remove(int n);
      if (hsize == 0 || n >= hsize) return;
      hsize--;
      swap_slots(n, hsize);
      heap_up(n);
      heap_down(n);
   endfunction

   function automatic void heap_reweigh(int n, int w);
      if (n >= hsize) return;
      wt[clip(hs[n])] = w & 8'hFF;
      heap_up(n);
      heap_down(n);
   endfunction

   function automatic void push_error_word(logic [1:0] code);
      cluster_word_type w;
      w.start = '0;
      w.length = '0;
      w.status = code;
      w.last = 1'b1;
      pending_clusters.push_back(w);
      pcount = 0;
      hsize = 0;
      eflags = 0;
   endfunction

   function automatic void absorb_point(logic signed [31:0] pos, logic last);
      cluster_word_type found[$];
      cluster_word_type w;
      longint d, lo;
      int n, r, start, len, k, cnt;
      d = longint'(width_q);
      if (pcount < MAX_POINTS) begin
         pts[pcount] = pos;
         pcount++;
      end else eflags |= 2;
      if (!last) return;
      if (eflags & 2) begin
         push_error_word(ST_OVERFLOW);
         return;
      end
      n = pcount;
      for (int i = 1; i < n; i++)
         if (pts[i - 1] > pts[i]) eflags |= 1;
      if (eflags & 1) begin
         push_error_word(ST_UNSORTED);
         return;
      end
      r = 0;
      for (int i = 0; i < n; i++) begin
         while (r < n && longint'(pts[r]) <= longint'(pts[i]) + d) r++;
         wt[i] = (r - i) & 8'hFF;
      end
      hsize = 0;
      for (int i = 0; i < n; i++) begin
         sp[i] = hsize;
         hs[hsize] = i;
         hsize++;
         heap_up(hsize - 1);
      end
      cnt = 0;
      while (hsize > 0 && cnt < MAX_POINTS) begin
         start = clip(hs[0]);
         len = wt[start];
         lo = longint'(pts[start]) - d;
         if (len == 0) len = 1;
         if (len > n - start) len = n - start;
         for (k = start; k < start + len; k++) begin
            if (sp[k] < MAX_POINTS) begin
               heap_remove(sp[k]);
               sp[k] = MAX_POINTS;
            end
         end
         for (k = 1; k <= start && longint'(pts[start - k]) >= lo; k++) begin
            if (sp[start - k] >= MAX_POINTS) break;
            heap_reweigh(sp[start - k], k);
         end
         w.start = start[5:0];
         w.length = len[6:0];
         w.status = ST_OK;
         w.last = (hsize == 0);
         found.push_back(w);
         cnt++;
      end
      if (found.size() > 0) found[found.size() - 1].last = 1'b1;
      foreach (found[i]) pending_clusters.push_back(found[i]);
      pcount = 0;
      hsize = 0;
      eflags = 0;
   endfunction

   // Result checker, receiver stall pattern and watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
         if (rsp_valid && rsp_ready) begin
            clusters_seen++;
            if (pending_clusters.size() == 0) begin
               $error("unexpected word start=%0d length=%0d", rsp_cluster_start,
                      rsp_cluster_length);
               errors++;
            end else begin
               cluster_word_type e;
               e = pending_clusters.pop_front();
               if (rsp_cluster_start !== e.start) begin
                  $error("cluster_start expected %0d got %0d", e.start, rsp_cluster_start);
                  errors++;
               end
               if (rsp_cluster_length !== e.length) begin
                  $error("cluster_length expected %0d got %0d", e.length,
                         rsp_cluster_length);
                  errors++;
               end
               if (rsp_status !== e.status) begin
                  $error("status expected %0d got %0d", e.status, rsp_status);
                  errors++;
               end
               if (rsp_last_result !== e.last) begin
                  $error("last_result expected %0d got %0d", e.last, rsp_last_result);
                  errors++;
               end
            end
         end
         if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 2) == 0);
            end
         endcase
      end
   end

   task automatic send_point(logic signed [31:0] pos, logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_position <= pos;
      req_last_point <= last;
      do @(posedge clock); while (!req_ready);
      absorb_point(pos, last);
      words_sent++;
      if (last) sets_sent++;
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_clusters.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_width(logic [31:0] value);
      drain_and_settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      width_q = value;
   endtask

   // Sends n points from base with random steps; a nonzero disorder swaps two.
   task automatic send_set(int n, longint base, int step_max, bit disorder);
      longint p[$];
      longint v;
      int a, b;
      v = base;
      for (int i = 0; i < n; i++) begin
         if (v > 64'sd2147483647) v = 64'sd2147483647;
         p.push_back(v);
         v = v + $urandom_range(0, step_max);
      end
      if (disorder && n > 1) begin
         a = $urandom_range(0, n - 2);
         b = a + 1;
         if (p[a] == p[b]) p[b] = p[a] - 1;
         v = p[a];
         p[a] = p[b];
         p[b] = v;
      end
      for (int i = 0; i < n; i++) send_point(32'(p[i]), i == n - 1);
   endtask

   task automatic test_directed();
      write_width(32'd0);
      send_point(32'sd5, 1'b1);
      send_point(-32'sd2147483648, 1'b0);
      send_point(-32'sd2147483648, 1'b0);
      send_point(32'sd0, 1'b0);
      send_point(32'sd2147483647, 1'b1);
      write_width(32'hFFFF_FFFF);
      send_point(-32'sd2147483648, 1'b0);
      send_point(32'sd0, 1'b0);
      send_point(32'sd2147483647, 1'b1);
      write_width(32'h0001_0000);
      send_point(32'sd0, 1'b0);
      send_point(32'sh0000_8000, 1'b0);
      send_point(32'sh0001_0000, 1'b0);
      send_point(32'sh0001_8000, 1'b0);
      send_point(32'sh0002_0000, 1'b0);
      send_point(32'sh0005_0000, 1'b1);
      send_point(32'sd100, 1'b0);
      send_point(32'sd99, 1'b0);
      send_point(32'sd200, 1'b1);
   endtask

   task automatic test_random_sets();
      longint base;
      logic [31:0] w;
      for (int s = 0; s < 6; s++) begin
         if (s % 2 == 0) begin
            case ($urandom_range(0, 3))
               0: w = $urandom_range(0, 8);
               1: w = $urandom_range(1, 4) << 16;
               2: w = $urandom();
               default: w = $urandom_range(0, 40);
            endcase
            write_width(w);
         end
         base = longint'($signed($urandom()));
         send_set($urandom_range(1, 12), base, ($urandom_range(0, 1) ? 10 : 70000),
                  $urandom_range(0, 7) == 0);
      end
   endtask

   task automatic test_full_and_overflow();
      write_width(32'd20);
      send_set(MAX_POINTS, longint'($signed($urandom())), 12, 1'b0);
      send_set(MAX_POINTS + 1, 0, 5, 1'b0);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_sets();
      test_full_and_overflow();
      drain_and_settle();
      $display("Covered %0d point words in %0d sets, %0d cluster words checked.",
               words_sent, sets_sent, clusters_seen);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
